// ===== design/htbp_pkg.sv =====
`timescale 1ns / 1ps

package htbp_pkg;

    // Largest side length accepted from the header.
    localparam int MAX_SIDE_DEF    = 4096;
    // Entries in each of the two queues.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Item kinds on the input channel.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Result error codes.
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_HEADER    = 3'd1;
    localparam logic [2:0] ERR_SIZE      = 3'd2;
    localparam logic [2:0] ERR_CHARACTER = 3'd3;
    localparam logic [2:0] ERR_TRUNCATED = 3'd4;

    typedef struct packed {
        logic       kind;
        logic [7:0] byte_value;
    } t_item;

    typedef struct packed {
        logic [7:0]  cell_value;
        logic [11:0] column;
        logic [11:0] row;
        logic [12:0] side_length;
        logic        map_complete;
        logic [2:0]  error_code;
    } t_result;

    // Byte classes seen by the parse engine.
    typedef enum logic [2:0] {
        TK_DIGIT,
        TK_BLANK,
        TK_LF,
        TK_CR,
        TK_OTHER,
        TK_END
    } t_tok_kind;

    typedef struct packed {
        t_tok_kind  kind;
        logic [3:0] digit;
        logic [7:0] byte_value;
    } t_token;

endpackage

// ===== design/htbp_fifo.sv =====
`timescale 1ns / 1ps

module htbp_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_full,
    input  T     i_data,
    input  logic i_pop,
    output logic o_empty,
    output T     o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T              r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ===== design/htbp_classify.sv =====
`timescale 1ns / 1ps

module htbp_classify import htbp_pkg::*; (
    input  t_item  i_item,
    output t_token o_token
);

    always_comb begin
        o_token.byte_value = i_item.byte_value;
        o_token.digit      = '0;
        o_token.kind       = TK_OTHER;
        if (i_item.kind == KIND_END) begin
            o_token.kind = TK_END;
        end else begin
            unique case (i_item.byte_value) inside
                [8'h30:8'h39]: begin
                    // '0' to '9'
                    o_token.kind  = TK_DIGIT;
                    o_token.digit = i_item.byte_value[3:0];
                end
                [8'h41:8'h46], [8'h61:8'h66]: begin
                    // 'A' to 'F', 'a' to 'f': low nibble 1..6 maps to 10..15
                    o_token.kind  = TK_DIGIT;
                    o_token.digit = i_item.byte_value[3:0] + 4'd9;
                end
                8'h20, 8'h09: o_token.kind = TK_BLANK;
                8'h0A:        o_token.kind = TK_LF;
                8'h0D:        o_token.kind = TK_CR;
                default:      o_token.kind = TK_OTHER;
            endcase
        end
    end

endmodule

// ===== design/htbp_engine.sv =====
`timescale 1ns / 1ps

module htbp_engine import htbp_pkg::*; #(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_token  i_token,
    input  logic    i_token_valid,
    output logic    o_token_take,
    input  logic    i_result_full,
    output logic    o_result_push,
    output t_result o_result
);

    localparam int SW  = $clog2(MAX_SIDE + 1);
    localparam int NVW = SW + 4;
    localparam logic [2:0] HDR_LEN = 3'd5;

    typedef enum logic [2:0] {
        PH_WORD,
        PH_NUM,
        PH_SKIP,
        PH_CELL,
        PH_DONE,
        PH_ERR
    } t_phase;

    t_phase        r_phase,      n_phase;
    logic [2:0]    r_match_idx,  n_match_idx;
    logic [SW-1:0] r_side,       n_side;
    logic          r_side_ovf,   n_side_ovf;
    logic          r_digit_seen, n_digit_seen;
    logic [7:0]    r_accum,      n_accum;
    logic [SW-1:0] r_col,        n_col;
    logic [SW-1:0] r_row,        n_row;

    logic [NVW-1:0] side_next;
    logic [SW:0]    col_inc;
    logic [SW:0]    row_inc;
    logic           last_col;
    logic           last_cell;

    // Header word "size " one character per index.
    function automatic logic [7:0] word_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h73; // 's'
            3'd1:    c = 8'h69; // 'i'
            3'd2:    c = 8'h7A; // 'z'
            3'd3:    c = 8'h65; // 'e'
            default: c = 8'h20; // ' '
        endcase
        return c;
    endfunction

    assign side_next = {r_side, 4'b0000} + NVW'(i_token.digit);
    assign col_inc   = (SW+1)'(r_col) + (SW+1)'(1);
    assign row_inc   = (SW+1)'(r_row) + (SW+1)'(1);
    assign last_col  = (col_inc >= (SW+1)'(r_side));
    assign last_cell = last_col && (row_inc >= (SW+1)'(r_side));

    always_comb begin
        n_phase       = r_phase;
        n_match_idx   = r_match_idx;
        n_side        = r_side;
        n_side_ovf    = r_side_ovf;
        n_digit_seen  = r_digit_seen;
        n_accum       = r_accum;
        n_col         = r_col;
        n_row         = r_row;
        o_token_take  = i_token_valid && !i_result_full;
        o_result_push = 1'b0;
        o_result      = '0;

        if (o_token_take) begin
            if (i_token.kind == TK_END) begin
                // End of input rearms everything.
                n_phase      = PH_WORD;
                n_match_idx  = '0;
                n_side       = '0;
                n_side_ovf   = 1'b0;
                n_digit_seen = 1'b0;
                n_accum      = '0;
                n_col        = '0;
                n_row        = '0;
                unique case (r_phase) inside
                    PH_WORD: begin
                        o_result_push       = 1'b1;
                        o_result.error_code = ERR_HEADER;
                    end
                    PH_NUM, PH_SKIP, PH_CELL: begin
                        o_result_push       = 1'b1;
                        o_result.error_code = ERR_TRUNCATED;
                    end
                    default: ;
                endcase
            end else begin
                unique case (r_phase)
                    PH_WORD: begin
                        if (r_match_idx < HDR_LEN &&
                            i_token.byte_value == word_char(r_match_idx)) begin
                            n_match_idx = r_match_idx + 3'd1;
                            if (n_match_idx == HDR_LEN) begin
                                n_phase = PH_NUM;
                            end
                        end else begin
                            n_phase             = PH_ERR;
                            o_result_push       = 1'b1;
                            o_result.error_code = ERR_HEADER;
                        end
                    end
                    PH_NUM: begin
                        if (!r_digit_seen && i_token.kind == TK_BLANK) begin
                            // skip leading blanks
                        end else if (i_token.kind == TK_DIGIT) begin
                            n_digit_seen = 1'b1;
                            if (!r_side_ovf) begin
                                if (side_next > NVW'(MAX_SIDE)) begin
                                    n_side_ovf = 1'b1;
                                end else begin
                                    n_side = side_next[SW-1:0];
                                end
                            end
                        end else if (!r_digit_seen || r_side_ovf || r_side == '0) begin
                            n_phase             = PH_ERR;
                            o_result_push       = 1'b1;
                            o_result.error_code = ERR_SIZE;
                        end else begin
                            n_phase = (i_token.kind == TK_LF) ? PH_CELL : PH_SKIP;
                        end
                    end
                    PH_SKIP: begin
                        if (i_token.kind == TK_LF) begin
                            n_phase = PH_CELL;
                        end
                    end
                    PH_CELL: begin
                        if (i_token.kind == TK_DIGIT) begin
                            n_accum = {r_accum[3:0], i_token.digit};
                        end else if (i_token.kind == TK_LF || i_token.kind == TK_CR) begin
                            o_result_push         = 1'b1;
                            o_result.cell_value   = r_accum;
                            o_result.column       = 12'(r_col);
                            o_result.row          = 12'(r_row);
                            o_result.side_length  = 13'(r_side);
                            o_result.map_complete = last_cell;
                            o_result.error_code   = ERR_NONE;
                            n_accum               = '0;
                            if (last_cell) begin
                                n_phase = PH_DONE;
                            end else if (last_col) begin
                                n_col = '0;
                                n_row = row_inc[SW-1:0];
                            end else begin
                                n_col = col_inc[SW-1:0];
                            end
                        end else begin
                            n_phase             = PH_ERR;
                            o_result_push       = 1'b1;
                            o_result.error_code = ERR_CHARACTER;
                        end
                    end
                    PH_DONE, PH_ERR: ;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_WORD;
            r_match_idx  <= '0;
            r_side       <= '0;
            r_side_ovf   <= 1'b0;
            r_digit_seen <= 1'b0;
            r_accum      <= '0;
            r_col        <= '0;
            r_row        <= '0;
        end else begin
            r_phase      <= n_phase;
            r_match_idx  <= n_match_idx;
            r_side       <= n_side;
            r_side_ovf   <= n_side_ovf;
            r_digit_seen <= n_digit_seen;
            r_accum      <= n_accum;
            r_col        <= n_col;
            r_row        <= n_row;
        end
    end

endmodule

// ===== design/hex_text_bytemap_parser_top.sv =====
`timescale 1ns / 1ps
// Hex text square-map parser.
// Input channel (push/full, i_item): one beat per file byte, or an end-of-input
// marker (kind set). A beat is taken on a clock edge with push high and full low.
// Result channel (empty/pop, o_result): the oldest result sits on o_result while
// empty is low and leaves on an edge with pop high. Each beat carries one cell
// (value, column, row, side, last-cell flag) or an error code with all other
// fields zero. Most bytes produce no result at all.
// Throughput: one input beat per cycle, sustained, as long as results are popped
// at the rate they appear; the parse engine handles one classified byte a cycle
// while the result queue has room. Path: a taken byte is stored in the byte
// queue, then taken by the engine, whose result is written into the result
// queue; that queue shows its head on o_result at once, ready to be popped.
// Stalls: when pop stays low the result queue fills, the engine holds, the byte
// queue fills, and full rises; nothing is dropped.
// Reset (synchronous, active low): both queues empty, parser back to expecting
// the header word. End of input also rearms the parser.
module hex_text_bytemap_parser_top import htbp_pkg::*; #(
    parameter int MAX_SIDE    = MAX_SIDE_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    push,
    output logic    full,
    input  t_item   i_item,
    output logic    empty,
    input  logic    pop,
    output t_result o_result
);

    t_token  class_token;
    t_token  queued_token;
    logic    token_empty;
    logic    token_take;
    logic    result_full;
    logic    result_push;
    t_result engine_result;

    // Front: classify each byte as it is taken.
    htbp_classify u_classify (
        .i_item  (i_item),
        .o_token (class_token)
    );

    // Decouple front from engine.
    htbp_fifo #(
        .T     (t_token),
        .DEPTH (QUEUE_DEPTH)
    ) u_token_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_data  (class_token),
        .i_pop   (token_take),
        .o_empty (token_empty),
        .o_data  (queued_token)
    );

    // Back: header match, side parse, cell accumulation and indexing.
    htbp_engine #(
        .MAX_SIDE (MAX_SIDE)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_token       (queued_token),
        .i_token_valid (!token_empty),
        .o_token_take  (token_take),
        .i_result_full (result_full),
        .o_result_push (result_push),
        .o_result      (engine_result)
    );

    // Hold results until the receiver pops them.
    htbp_fifo #(
        .T     (t_result),
        .DEPTH (QUEUE_DEPTH)
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (result_push),
        .o_full  (result_full),
        .i_data  (engine_result),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (o_result)
    );

endmodule

// ===== design/htbp_checker.sv =====
`timescale 1ns / 1ps

module htbp_checker import htbp_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    full,
    input logic    empty,
    input logic    pop,
    input t_result o_result
);

    // Queues come out of reset empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    // An error beat carries nothing but its code.
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.error_code != ERR_NONE) |->
            (o_result.cell_value == '0 && o_result.column == '0 &&
             o_result.row == '0 && o_result.side_length == '0 &&
             !o_result.map_complete))
        else $error("error result with nonzero fields");

    // The last cell sits in the bottom right corner.
    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.map_complete) |->
            (o_result.error_code == ERR_NONE &&
             o_result.column == 12'(o_result.side_length - 13'd1) &&
             o_result.row == 12'(o_result.side_length - 13'd1)))
        else $error("last cell not at the map corner");

    // A waiting result holds until popped.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("stalled result changed");

endmodule

bind hex_text_bytemap_parser_top htbp_checker u_checker (.*);
